// ===== sv/tbr_pkg.sv =====
// Shared types and constants of the TFTP block receiver.
package tbr_pkg;

  // Transfer geometry
  localparam int MAX_BLOCKS  = 32768;
  localparam int BLOCK_BYTES = 512;
  localparam int HDR_BYTES   = 4;
  localparam int BLK_SHIFT   = $clog2(BLOCK_BYTES);

  // Received-block bitmap: one bit per block, packed into words
  localparam int MAP_WORD_W = 32;
  localparam int MAP_WORDS  = (MAX_BLOCKS + MAP_WORD_W - 1) / MAP_WORD_W;
  localparam int MAP_AW     = $clog2(MAP_WORDS);
  localparam int BIT_AW     = $clog2(MAP_WORD_W);
  localparam int PREFIX_W   = $clog2(MAX_BLOCKS + 1);

  localparam logic [15:0] MAX_BLK = 16'(MAX_BLOCKS);

  // Configuration
  localparam int          PADDR_W            = 3;
  localparam logic        REG_LOAD_ADDRESS   = 1'b0;
  localparam logic [31:0] LOAD_ADDRESS_RESET = 32'h5000_8000;

  // Request kinds and TFTP opcodes
  localparam logic        KIND_START = 1'b0;
  localparam logic [15:0] OP_DATA    = 16'd3;
  localparam logic [15:0] OP_ERROR   = 16'd5;
  localparam logic [15:0] OP_OACK    = 16'd6;

  // Result status codes
  localparam logic [2:0] ST_DATA     = 3'd0;
  localparam logic [2:0] ST_BAD      = 3'd1;
  localparam logic [2:0] ST_OACK     = 3'd2;
  localparam logic [2:0] ST_PEER_ERR = 3'd3;
  localparam logic [2:0] ST_UNKNOWN  = 3'd4;
  localparam logic [2:0] ST_STARTED  = 3'd5;

  typedef struct packed {
    logic        kind;
    logic [15:0] opcode;
    logic [15:0] block_number;
    logic [10:0] packet_length;
    logic [15:0] reply_port;
  } pkt_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        ack_valid;
    logic [15:0] ack_block;
    logic [15:0] ack_port;
    logic        store_valid;
    logic [31:0] store_address;
    logic [9:0]  store_bytes;
    logic        transfer_done;
    logic [24:0] bytes_total;
  } res_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic clear_state;
    logic clr_step;
    logic rd_blk;
    logic mark;
    logic rd_scan;
    logic scan_step;
    logic load_res;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_start;
    logic is_good;
    logic clr_last;
    logic scan_needed;
    logic scan_more;
  } sts_t;

endpackage

// ===== sv/tbr_dp.sv =====
// Datapath of the TFTP block receiver: request register, bitmap memory, records, result.
module tbr_dp import tbr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  pkt_t        pkt,
  input  cmd_t        cmd,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  output logic [31:0] load_address,
  output sts_t        sts,
  output res_t        res
);

  pkt_t                  item;
  logic [15:0]           final_block;
  logic [9:0]            final_length;
  logic [PREFIX_W-1:0]   prefix;
  logic                  fresh;
  logic [MAP_AW-1:0]     clr_addr;
  logic [MAP_WORD_W-1:0] mem [MAP_WORDS];
  logic [MAP_WORD_W-1:0] rd_data;

  logic                  is_data, blk_ok, len_ok, is_good, is_start;
  logic [15:0]           blk_idx;
  logic [MAP_AW-1:0]     blk_word;
  logic [BIT_AW-1:0]     blk_bit;
  logic [9:0]            pay;
  logic                  short_pay;
  logic                  cur_bit;
  logic                  rd_en, wr_en;
  logic [MAP_AW-1:0]     rd_addr, wr_addr;
  logic [MAP_WORD_W-1:0] wr_data;
  logic [MAP_WORD_W-1:0] low_mask, filled;
  logic                  all_set;
  logic [BIT_AW-1:0]     zidx;
  logic [PREFIX_W-1:0]   next_base;
  logic                  done;
  logic [24:0]           total;
  res_t                  res_next;

  // Request decode
  assign is_start  = item.kind == KIND_START;
  assign is_data   = !is_start && item.opcode == OP_DATA;
  assign blk_ok    = item.block_number != 16'd0 && item.block_number <= MAX_BLK;
  assign len_ok    = item.packet_length >= 11'(HDR_BYTES) &&
                     item.packet_length <= 11'(BLOCK_BYTES + HDR_BYTES);
  assign is_good   = is_data && blk_ok && len_ok;
  assign blk_idx   = item.block_number - 16'd1;
  assign blk_word  = blk_idx[BIT_AW +: MAP_AW];
  assign blk_bit   = blk_idx[BIT_AW-1:0];
  assign pay       = 10'(item.packet_length - 11'(HDR_BYTES));
  assign short_pay = pay < 10'(BLOCK_BYTES);
  assign cur_bit   = rd_data[blk_bit];

  // Bitmap memory ports
  assign rd_en   = cmd.rd_blk || cmd.rd_scan;
  assign rd_addr = cmd.rd_scan ? prefix[BIT_AW +: MAP_AW] : blk_word;
  assign wr_en   = cmd.clr_step || (cmd.mark && !cur_bit);
  assign wr_addr = cmd.clr_step ? clr_addr : blk_word;
  assign wr_data = cmd.clr_step ? '0 : (rd_data | (MAP_WORD_W'(1) << blk_bit));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Prefix scan: find the first unreceived block at or above prefix
  assign low_mask  = ~({MAP_WORD_W{1'b1}} << prefix[BIT_AW-1:0]);
  assign filled    = rd_data | low_mask;
  assign all_set   = &filled;
  assign next_base = {prefix[PREFIX_W-1:BIT_AW] + 1'b1, {BIT_AW{1'b0}}};

  always_comb begin
    zidx = '0;
    for (int i = MAP_WORD_W - 1; i >= 0; i--) begin
      if (!filled[i]) begin
        zidx = BIT_AW'(i);
      end
    end
  end

  // Status to the controller
  always_comb begin
    sts.is_start    = is_start;
    sts.is_good     = is_good;
    sts.clr_last    = clr_addr == MAP_AW'(MAP_WORDS - 1);
    sts.scan_needed = !cur_bit && PREFIX_W'(blk_idx) == prefix;
    sts.scan_more   = all_set && next_base < PREFIX_W'(MAX_BLOCKS);
  end

  // Completion: blocks 1..prefix are all received
  assign done  = final_block != 16'd0 && PREFIX_W'(final_block) <= prefix;
  assign total = 25'({final_block - 16'd1, {BLK_SHIFT{1'b0}}}) + 25'(final_length);

  // Result assembly
  always_comb begin
    res_next = '0;
    if (is_start) begin
      res_next.status = ST_STARTED;
    end else if (is_data) begin
      res_next.status = is_good ? ST_DATA : ST_BAD;
    end else if (item.opcode == OP_OACK) begin
      res_next.status = ST_OACK;
    end else if (item.opcode == OP_ERROR) begin
      res_next.status = ST_PEER_ERR;
    end else begin
      res_next.status = ST_UNKNOWN;
    end
    if (is_good) begin
      res_next.ack_valid = 1'b1;
      res_next.ack_block = item.block_number;
      res_next.ack_port  = item.reply_port;
    end
    if (is_good && fresh) begin
      res_next.store_valid   = 1'b1;
      res_next.store_address = load_address + 32'({blk_idx, {BLK_SHIFT{1'b0}}});
      res_next.store_bytes   = pay;
    end
    if (done) begin
      res_next.transfer_done = 1'b1;
      res_next.bytes_total   = total;
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= pkt;
    end
  end

  // Records, scan pointer, clear counter and result
  always_ff @(posedge clk) begin
    if (rst) begin
      load_address <= LOAD_ADDRESS_RESET;
      final_block  <= '0;
      final_length <= '0;
      prefix       <= '0;
      fresh        <= 1'b0;
      clr_addr     <= '0;
      res          <= '0;
    end else begin
      if (cfg_we) begin
        load_address <= cfg_data;
      end
      if (cmd.capture) begin
        fresh <= 1'b0;
      end else if (cmd.mark) begin
        fresh <= !cur_bit;
      end
      if (cmd.clear_state) begin
        final_block  <= '0;
        final_length <= '0;
        prefix       <= '0;
        clr_addr     <= '0;
      end else begin
        if (cmd.clr_step) begin
          clr_addr <= clr_addr + 1'b1;
        end
        if (cmd.mark && short_pay) begin
          final_block  <= item.block_number;
          final_length <= pay;
        end
        if (cmd.scan_step) begin
          prefix <= all_set ? next_base : {prefix[PREFIX_W-1:BIT_AW], zidx};
        end
      end
      if (cmd.load_res) begin
        res <= res_next;
      end
    end
  end

`ifndef SYNTH
  a_prefix_range: assert property (@(posedge clk) disable iff (rst)
    prefix <= PREFIX_W'(MAX_BLOCKS))
    else $error("scan pointer beyond last block");

  a_store_has_ack: assert property (@(posedge clk) disable iff (rst)
    res.store_valid |-> (res.ack_valid && res.status == ST_DATA))
    else $error("store issued without acknowledgement");

  a_done_has_final: assert property (@(posedge clk) disable iff (rst)
    cmd.load_res && done |-> final_block != 16'd0 && final_block <= MAX_BLK)
    else $error("done reported without a valid last block");
`endif

endmodule

// ===== sv/tbr_ctrl.sv =====
// Controller of the TFTP block receiver: sequencing of clear, mark, scan and result.
module tbr_ctrl import tbr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic pkt_valid,
  output logic pkt_stall,
  output logic res_valid,
  input  logic res_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLR_INIT,
    S_IDLE,
    S_DISPATCH,
    S_CLR_START,
    S_MARK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_FINISH
  } state_t;

  state_t state, state_next;
  logic   slot_free;

  assign pkt_stall = state != S_IDLE;
  assign slot_free = !res_valid || !res_stall;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLR_INIT: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (pkt_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.is_start) begin
          cmd.clear_state = 1'b1;
          state_next      = S_CLR_START;
        end else if (sts.is_good) begin
          cmd.rd_blk = 1'b1;
          state_next = S_MARK;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_CLR_START: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = S_FINISH;
        end
      end
      S_MARK: begin
        cmd.mark   = 1'b1;
        state_next = sts.scan_needed ? S_SCAN_RD : S_FINISH;
      end
      S_SCAN_RD: begin
        cmd.rd_scan = 1'b1;
        state_next  = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        cmd.scan_step = 1'b1;
        state_next    = sts.scan_more ? S_SCAN_RD : S_FINISH;
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd.load_res = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and output slot
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR_INIT;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_res) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> pkt_stall)
    else $error("second request taken while one is in work");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_res |-> (!res_valid || !res_stall))
    else $error("result overwritten before it was taken");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_res |=> res_valid)
    else $error("loaded result not presented");
`endif

endmodule

// ===== sv/tftp_block_receiver.sv =====
// TFTP read client receive side: usage notes
// Requests enter on pkt (pkt_valid / pkt_stall): a start event or a decoded TFTP
// packet header. Each request gives exactly one result on res (res_valid /
// res_stall): status, acknowledgement, store command and completion report.
// The APB port holds load_address at byte address 0 (pready always high).
// One request is in work at a time; pkt_stall stays high until its result is in
// the output register. A start event clears the whole received-block bitmap, and
// data that fills the first missing block starts a scan of the bitmap words.
// The prefix scan reads and the bitmap clear writes the single bitmap memory,
// which has separate read and write ports.
// After reset the block clears the whole bitmap with pkt_stall high;
// configuration writes are taken during that time.
// While res_stall is high the finished result is held; the next request may
// still be accepted and worked, and waits only before loading its result.
module tftp_block_receiver import tbr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               pkt_valid,
  output logic               pkt_stall,
  input  pkt_t               pkt,
  output logic               res_valid,
  input  logic               res_stall,
  output res_t               res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cmd_t        cmd;
  sts_t        sts;
  logic        cfg_we;
  logic [31:0] load_address;

  // Register access
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && paddr[PADDR_W-1:2] == REG_LOAD_ADDRESS;
  assign prdata = (paddr[PADDR_W-1:2] == REG_LOAD_ADDRESS) ? load_address : '0;

  tbr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .pkt_valid (pkt_valid),
    .pkt_stall (pkt_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  tbr_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .pkt          (pkt),
    .cmd          (cmd),
    .cfg_we       (cfg_we),
    .cfg_data     (pwdata),
    .load_address (load_address),
    .sts          (sts),
    .res          (res)
  );

endmodule

// ===== dv/tbr_checker.sv =====
// Checker for the TFTP block receiver: predicts each reply and compares it with the block.
`timescale 1ns / 1ps

module tbr_checker import tbr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               pkt_valid,
  input  logic               pkt_stall,
  input  pkt_t               pkt,
  input  logic               res_valid,
  input  logic               res_stall,
  input  res_t               res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 open_reqs
);

  localparam logic [PADDR_W-1:0] LOAD_ADDR_OFS = PADDR_W'(4 * int'(REG_LOAD_ADDRESS));

  // Shadow of the receiver state
  logic [31:0] base_addr;
  bit          got_block [int];
  logic [15:0] last_blk;
  logic [9:0]  tail_len;
  int          filled_upto;   // blocks 1..filled_upto are all received

  res_t expected_replies [$];
  int   mismatches = 0;
  int   outstanding = 0;

  assign fail_count = mismatches;
  assign open_reqs  = outstanding;

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    end
  endtask

  task automatic compare_reply(input res_t got, input res_t want);
    check_field("status", got.status, want.status);
    check_field("ack_valid", got.ack_valid, want.ack_valid);
    check_field("ack_block", got.ack_block, want.ack_block);
    check_field("ack_port", got.ack_port, want.ack_port);
    check_field("store_valid", got.store_valid, want.store_valid);
    check_field("store_address", got.store_address, want.store_address);
    check_field("store_bytes", got.store_bytes, want.store_bytes);
    check_field("transfer_done", got.transfer_done, want.transfer_done);
    check_field("bytes_total", got.bytes_total, want.bytes_total);
  endtask

  // Reply to one request; updates the shadow state
  function automatic res_t predict_reply(input pkt_t p);
    res_t r;
    int   blk;
    int   pay;
    r   = '0;
    blk = int'(p.block_number);
    if (p.kind == KIND_START) begin
      got_block.delete();
      last_blk    = '0;
      tail_len    = '0;
      filled_upto = 0;
      r.status    = ST_STARTED;
    end else if (p.opcode == OP_DATA) begin
      if (blk == 0 || blk > MAX_BLOCKS || int'(p.packet_length) < HDR_BYTES ||
          int'(p.packet_length) > BLOCK_BYTES + HDR_BYTES) begin
        r.status = ST_BAD;
      end else begin
        pay = int'(p.packet_length) - HDR_BYTES;
        // first copy of a block gets stored
        if (!got_block.exists(blk)) begin
          got_block[blk]  = 1'b1;
          r.store_valid   = 1'b1;
          r.store_address = base_addr + 32'((blk - 1) * BLOCK_BYTES);
          r.store_bytes   = 10'(pay);
          while (got_block.exists(filled_upto + 1)) filled_upto++;
        end
        // short payload marks the end of the file
        if (pay < BLOCK_BYTES) begin
          last_blk = p.block_number;
          tail_len = 10'(pay);
        end
        r.status    = ST_DATA;
        r.ack_valid = 1'b1;
        r.ack_block = p.block_number;
        r.ack_port  = p.reply_port;
      end
    end else if (p.opcode == OP_OACK) begin
      r.status = ST_OACK;
    end else if (p.opcode == OP_ERROR) begin
      r.status = ST_PEER_ERR;
    end else begin
      r.status = ST_UNKNOWN;
    end
    // completion is judged on every request
    if (last_blk != '0 && int'(last_blk) <= filled_upto) begin
      r.transfer_done = 1'b1;
      r.bytes_total   = 25'((int'(last_blk) - 1) * BLOCK_BYTES + int'(tail_len));
    end
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      base_addr   = LOAD_ADDRESS_RESET;
      got_block.delete();
      last_blk    = '0;
      tail_len    = '0;
      filled_upto = 0;
      expected_replies.delete();
      outstanding <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == LOAD_ADDR_OFS) begin
        base_addr = pwdata;
      end
      // replies leave before a new request is predicted
      if (res_valid && !res_stall) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("reply with no request outstanding");
        end else begin
          want = expected_replies.pop_front();
          compare_reply(res, want);
        end
      end
      if (pkt_valid && !pkt_stall) begin
        expected_replies.push_back(predict_reply(pkt));
      end
      outstanding <= expected_replies.size();
    end
  end

endmodule

// ===== dv/tb_tftp_block_receiver.sv =====
// Testbench top for the TFTP block receiver: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_tftp_block_receiver;
  import tbr_pkg::*;

  localparam logic [PADDR_W-1:0] LOAD_ADDR_OFS = PADDR_W'(4 * int'(REG_LOAD_ADDRESS));
  localparam int                 RANDOM_ITEMS  = 600;
  localparam int unsigned        CYCLE_LIMIT   = 4_000_000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               pkt_valid = 1'b0;
  logic               pkt_stall;
  pkt_t               pkt = '0;
  logic               res_valid;
  logic               res_stall = 1'b0;
  res_t               res;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  int          fail_count;
  int          open_reqs;
  int          burst_left = 0;
  int          sent = 0;
  int unsigned cycles = 0;

  always #5 clk = ~clk;

  tftp_block_receiver dut (
    .clk(clk), .rst(rst),
    .pkt_valid(pkt_valid), .pkt_stall(pkt_stall), .pkt(pkt),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  tbr_checker chk (
    .clk(clk), .rst(rst),
    .pkt_valid(pkt_valid), .pkt_stall(pkt_stall), .pkt(pkt),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fail_count(fail_count), .open_reqs(open_reqs)
  );

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Reply side stalls in stretches of changing density
  initial begin
    int stall_mode;
    int stall_left;
    stall_mode = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(10, 200);
      end
      stall_left--;
      case (stall_mode)
        0:       res_stall <= 1'b0;
        1:       res_stall <= 1'($urandom_range(0, 1));
        2:       res_stall <= ($urandom_range(0, 7) == 0);
        default: res_stall <= ($urandom_range(0, 15) != 0);
      endcase
    end
  end

  function automatic pkt_t make_pkt(input logic k, input logic [15:0] op,
                                    input logic [15:0] blk, input logic [10:0] len,
                                    input logic [15:0] port);
    pkt_t p;
    p.kind          = k;
    p.opcode        = op;
    p.block_number  = blk;
    p.packet_length = len;
    p.reply_port    = port;
    return p;
  endfunction

  // Arbitrary header: mostly packets, now and then a start
  function automatic pkt_t noise_item();
    pkt_t p;
    p.kind = ($urandom_range(0, 15) != 0);
    case ($urandom_range(0, 4))
      0:       p.opcode = OP_DATA;
      1:       p.opcode = OP_OACK;
      2:       p.opcode = OP_ERROR;
      default: p.opcode = 16'($urandom);
    endcase
    p.block_number = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 40));
    case ($urandom_range(0, 3))
      0:       p.packet_length = 11'($urandom_range(0, 2047));
      1:       p.packet_length = $urandom_range(0, 1) ? 11'd3 : 11'd517;
      default: p.packet_length = 11'($urandom_range(4, 516));
    endcase
    p.reply_port = 16'($urandom);
    return p;
  endfunction

  // One request; the sender works in bursts with gaps between them
  task automatic issue(input pkt_t p);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      if (gap > 0) begin
        pkt_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    pkt       <= p;
    pkt_valid <= 1'b1;
    do @(posedge clk); while (pkt_stall);
    sent++;
  endtask

  // Drain every outstanding reply before touching the register
  task automatic wait_idle();
    pkt_valid  <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (open_reqs != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_load_address(input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LOAD_ADDR_OFS;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // A file of 1..n blocks, with reordering, resends, stray packets and holes
  task automatic run_transfer();
    int          n;
    int          a;
    int          b;
    int          tmp;
    int          tail_len;
    logic [15:0] port;
    int          blocks [$];
    n        = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
    port     = 16'($urandom);
    case ($urandom_range(0, 3))
      0:       tail_len = HDR_BYTES;
      1:       tail_len = BLOCK_BYTES + HDR_BYTES - 1;
      default: tail_len = $urandom_range(HDR_BYTES, BLOCK_BYTES + HDR_BYTES - 1);
    endcase
    if ($urandom_range(0, 9) != 0) begin
      issue(make_pkt(KIND_START, 16'($urandom), 16'($urandom), 11'($urandom), 16'($urandom)));
    end
    for (int k = 1; k <= n; k++) blocks.push_back(k);
    repeat ($urandom_range(0, 3)) begin
      a = $urandom_range(0, n - 1);
      b = $urandom_range(0, n - 1);
      tmp = blocks[a];
      blocks[a] = blocks[b];
      blocks[b] = tmp;
    end
    if ($urandom_range(0, 9) == 0) blocks.delete($urandom_range(0, n - 1));
    foreach (blocks[i]) begin
      b = blocks[i];
      tmp = (b == n) ? tail_len : BLOCK_BYTES + HDR_BYTES;
      issue(make_pkt(1'b1, OP_DATA, 16'(b), 11'(tmp), port));
      // lost ack: the server sends the block again
      if ($urandom_range(0, 9) == 0) issue(make_pkt(1'b1, OP_DATA, 16'(b), 11'(tmp), port));
      if ($urandom_range(0, 11) == 0) issue(noise_item());
    end
  endtask

  initial begin
    logic [31:0] addr;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: data before any start, at the reset load address
    issue(make_pkt(1'b1, OP_DATA, 16'd1, 11'd100, 16'h1234));
    issue(make_pkt(KIND_START, 16'hFFFF, 16'hFFFF, 11'h7FF, 16'hFFFF));
    issue(make_pkt(1'b1, OP_DATA, 16'd1, 11'd516, 16'hFFFF));
    issue(make_pkt(1'b1, OP_DATA, 16'd2, 11'd516, 16'h0000));
    // resend of a stored block, then an empty last block
    issue(make_pkt(1'b1, OP_DATA, 16'd1, 11'd516, 16'hA5A5));
    issue(make_pkt(1'b1, OP_DATA, 16'd3, 11'd4, 16'h5A5A));
    // repeated last block with a new length
    issue(make_pkt(1'b1, OP_DATA, 16'd3, 11'd300, 16'h5A5A));
    // bad block numbers and lengths
    issue(make_pkt(1'b1, OP_DATA, 16'd0, 11'd100, 16'h0001));
    issue(make_pkt(1'b1, OP_DATA, MAX_BLK + 16'd1, 11'd100, 16'h0001));
    issue(make_pkt(1'b1, OP_DATA, 16'hFFFF, 11'd516, 16'h0001));
    issue(make_pkt(1'b1, OP_DATA, 16'd5, 11'd3, 16'h0001));
    issue(make_pkt(1'b1, OP_DATA, 16'd5, 11'd517, 16'h0001));
    issue(make_pkt(1'b1, OP_DATA, 16'd5, 11'h7FF, 16'h0001));
    issue(make_pkt(1'b1, OP_DATA, 16'd5, 11'd0, 16'h0001));
    // non-data opcodes
    issue(make_pkt(1'b1, OP_OACK, 16'd1, 11'd20, 16'h0002));
    issue(make_pkt(1'b1, OP_ERROR, 16'd1, 11'd20, 16'h0002));
    issue(make_pkt(1'b1, 16'h0000, 16'd1, 11'd516, 16'h0002));
    issue(make_pkt(1'b1, 16'hFFFF, 16'd1, 11'd516, 16'h0002));
    issue(make_pkt(1'b1, 16'd4, 16'd1, 11'd516, 16'h0002));
    issue(make_pkt(KIND_START, '0, '0, '0, '0));
    // store address wraps past the top of memory
    wait_idle();
    write_load_address(32'hFFFF_FE00);
    issue(make_pkt(1'b1, OP_DATA, MAX_BLK, 11'd4, 16'h0003));
    issue(make_pkt(1'b1, OP_DATA, 16'd2, 11'd516, 16'h0003));
    wait_idle();
    write_load_address(32'h0000_0000);
    issue(make_pkt(1'b1, OP_DATA, 16'd1, 11'd516, 16'h0003));

    // Random phases
    while (sent < RANDOM_ITEMS + 25) begin
      wait_idle();
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 3))
          0:       addr = 32'h0000_0000;
          1:       addr = 32'hFFFF_FFFF;
          2:       addr = LOAD_ADDRESS_RESET;
          default: addr = $urandom;
        endcase
        write_load_address(addr);
      end
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(5, 15)) issue(noise_item());
      end else begin
        run_transfer();
      end
    end

    // Drain and give the verdict
    pkt_valid <= 1'b0;
    do @(posedge clk); while (open_reqs != 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && open_reqs == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
